>>> rtl/drop_oldest_event_fifo_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the drop-oldest event queue
// Clocked assertions, with and without a reset that disables them.
// ---------------------------------------------------------------------------
`ifndef DROP_OLDEST_EVENT_FIFO_MACROS_SVH
`define DROP_OLDEST_EVENT_FIFO_MACROS_SVH

`ifndef SYNTHESIS
`define DOF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DOF_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DOF_ASSERT(label, clk, rst, prop, msg)
`define DOF_ASSERT_NR(label, clk, prop, msg)
`endif

`endif

>>> rtl/dofifo_pkg.sv
// ---------------------------------------------------------------------------
// dofifo_pkg
// Constants, codes and shared types of the drop-oldest event queue.
// ---------------------------------------------------------------------------
`default_nettype none

package dofifo_pkg;

   localparam int DEPTH         = 1024;
   localparam int PAYLOAD_WIDTH = 32;
   localparam int DRAIN_LIMIT   = 64;

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int STORE_W = (PAYLOAD_WIDTH < 32) ? PAYLOAD_WIDTH : 32;
   localparam int SEQ_W   = 64;
   localparam int ENTRY_W = STORE_W + SEQ_W;

   localparam logic [1:0] FN_PUBLISH = 2'd0;
   localparam logic [1:0] FN_DRAIN   = 2'd1;
   localparam logic [1:0] FN_CLEAR   = 2'd2;
   localparam logic [1:0] FN_STATUS  = 2'd3;

   localparam logic KIND_EVENT  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic                 wr_en;
      ptr_type              wr_addr;
      logic [ENTRY_W-1:0]   wr_data;
      logic                 rd_en;
      ptr_type              rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic        valid;
      logic        kind;
      logic        last;
      logic [10:0] pending;
      logic [63:0] dropped;
   } rsp_side_type;

   function automatic ptr_type advance(input ptr_type p);
      if (p == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   function automatic logic [10:0] pending_field(input cnt_type c);
      logic [31:0] wide;
      wide = 32'(c);
      return wide[10:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/dofifo_ram.sv
// ---------------------------------------------------------------------------
// dofifo_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module dofifo_ram #(
   parameter int WIDTH  = 96,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/dofifo_ctrl.sv
// ---------------------------------------------------------------------------
// dofifo_ctrl
// Pointers, counters and drain sequencer; issues store reads and writes.
// ---------------------------------------------------------------------------
`default_nettype none
`include "drop_oldest_event_fifo_macros.svh"

module dofifo_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output      logic                    busy,
   input  wire logic [1:0]              req_func,
   input  wire logic [31:0]             req_payload,
   input  wire logic [6:0]              req_drain_max,
   output      dofifo_pkg::mem_req_type mem_req,
   output      dofifo_pkg::rsp_side_type rsp_side
);
   import dofifo_pkg::*;

   localparam logic [0:0] ST_IDLE  = 1'b0;
   localparam logic [0:0] ST_DRAIN = 1'b1;

   logic [0:0]   state_ff, state_in;
   ptr_type      head_ff, head_in;
   ptr_type      tail_ff, tail_in;
   cnt_type      cnt_ff, cnt_in;
   logic [63:0]  seq_ff, seq_in;
   logic [63:0]  drop_ff, drop_in;
   logic [6:0]   rem_ff, rem_in;
   rsp_side_type rsp_ff, rsp_in;

   logic         accept;
   logic [6:0]   want;
   logic [6:0]   take_n;
   logic [31:0]  cnt_wide;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign rsp_side = rsp_ff;

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      cnt_in   = cnt_ff;
      seq_in   = seq_ff;
      drop_in  = drop_ff;
      rem_in   = rem_ff;
      rsp_in   = '0;
      mem_req  = '0;
      cnt_wide = 32'(cnt_ff);
      want     = (req_drain_max > 7'(DRAIN_LIMIT)) ? 7'(DRAIN_LIMIT) : req_drain_max;
      take_n   = (32'(want) > cnt_wide) ? cnt_wide[6:0] : want;

      if (accept) begin
         case (req_func)
            FN_PUBLISH: begin
               seq_in          = seq_ff + 64'd1;
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = tail_ff;
               mem_req.wr_data = {req_payload[STORE_W-1:0], seq_in};
               tail_in         = advance(tail_ff);
               // full: drop the oldest entry, count stays at depth
               if (cnt_ff == CNT_W'(DEPTH)) begin
                  drop_in = drop_ff + 64'd1;
                  head_in = advance(head_ff);
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
            FN_DRAIN: begin
               rem_in = take_n;
               if (take_n != 7'd0) begin
                  state_in = ST_DRAIN;
               end
            end
            FN_CLEAR: begin
               head_in = '0;
               tail_in = '0;
               cnt_in  = '0;
               drop_in = '0;
            end
            default: begin
               rsp_in.valid   = 1'b1;
               rsp_in.kind    = KIND_STATUS;
               rsp_in.last    = 1'b1;
               rsp_in.pending = pending_field(cnt_ff);
               rsp_in.dropped = drop_ff;
            end
         endcase
      end else if (state_ff == ST_DRAIN) begin
         // read the head entry; its data lands with the registered response
         mem_req.rd_en   = 1'b1;
         mem_req.rd_addr = head_ff;
         head_in         = advance(head_ff);
         cnt_in          = cnt_ff - CNT_W'(1);
         rem_in          = rem_ff - 7'd1;
         rsp_in.valid    = 1'b1;
         rsp_in.kind     = KIND_EVENT;
         rsp_in.last     = (rem_ff == 7'd1);
         rsp_in.pending  = pending_field(cnt_in);
         rsp_in.dropped  = drop_ff;
         if (rem_ff == 7'd1) begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         cnt_ff       <= '0;
         seq_ff       <= '0;
         drop_ff      <= '0;
         rem_ff       <= '0;
         rsp_ff.valid <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cnt_ff       <= cnt_in;
         seq_ff       <= seq_in;
         drop_ff      <= drop_in;
         rem_ff       <= rem_in;
         rsp_ff.valid <= rsp_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff.kind    <= rsp_in.kind;
      rsp_ff.last    <= rsp_in.last;
      rsp_ff.pending <= rsp_in.pending;
      rsp_ff.dropped <= rsp_in.dropped;
   end

   `DOF_ASSERT(a_ptr_meet, clock, reset, (cnt_ff == '0 || cnt_ff == CNT_W'(DEPTH)) |-> (head_ff == tail_ff), "pointers disagree with count")
   `DOF_ASSERT(a_drain_nonempty, clock, reset, (state_ff == ST_DRAIN) |-> (rem_ff != 7'd0 && cnt_ff != '0), "drain runs past the queue")
   `DOF_ASSERT(a_event_from_drain, clock, reset, (rsp_ff.valid && rsp_ff.kind == KIND_EVENT) |-> $past(state_ff == ST_DRAIN), "event result without a drain read")
   `DOF_ASSERT(a_drain_end_last, clock, reset, $fell(busy) |-> (rsp_ff.valid && rsp_ff.last), "drain ended without a last result")

endmodule

`default_nettype wire

>>> rtl/drop_oldest_event_fifo.sv
// Drop-oldest event queue, DEPTH entries held in one synchronous RAM.
// Publish and clear give no result.
// Status: one result, on the ports the cycle after the accepting edge.
// Drain of n entries: busy while it reads, one result per cycle through the
// RAM's registered read port, after the drain state and read registers.
// Reset clears pointers, counters and the sequence stamp; the stores are not swept.
`default_nettype none

module drop_oldest_event_fifo (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [1:0]  req_func,
   input  wire logic [31:0] req_payload,
   input  wire logic [6:0]  req_drain_max,
   output      logic        rsp_valid,
   output      logic        rsp_kind,
   output      logic [31:0] rsp_payload_out,
   output      logic [63:0] rsp_sequence_out,
   output      logic        rsp_last,
   output      logic [10:0] rsp_pending,
   output      logic [63:0] rsp_dropped
);
   import dofifo_pkg::*;

   mem_req_type        mem_req;
   rsp_side_type       rsp_side;
   logic [ENTRY_W-1:0] rd_data;
   logic               is_event;

   dofifo_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_payload   (req_payload),
      .req_drain_max (req_drain_max),
      .mem_req       (mem_req),
      .rsp_side      (rsp_side)
   );

   dofifo_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_data)
   );

   // status replies carry zero payload and stamp
   assign is_event         = (rsp_side.kind == KIND_EVENT);
   assign rsp_valid        = rsp_side.valid;
   assign rsp_kind         = rsp_side.kind;
   assign rsp_last         = rsp_side.last;
   assign rsp_pending      = rsp_side.pending;
   assign rsp_dropped      = rsp_side.dropped;
   assign rsp_payload_out  = is_event ? 32'(rd_data[ENTRY_W-1:SEQ_W]) : 32'd0;
   assign rsp_sequence_out = is_event ? rd_data[SEQ_W-1:0] : 64'd0;

endmodule

`default_nettype wire
